/* rtl/fvn_pkg.sv */
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared types and constants of the fractal value noise block: cosine weight
// table, hash constants, register indexes and controller/datapath signals.
// ----------------------------------------------------------------------------
package fvn_pkg;

    // cosine weight table
    localparam int CURVE_ENTRIES = 256;
    localparam int CURVE_IDX_W   = 8;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef logic [CURVE_ENTRIES-1:0][16:0] curve_tab_t;

    // (1 + cos(pi*i/N)) / 2 in Q1.16, taylor series in Q30
    function automatic curve_tab_t build_curve();
        curve_tab_t        tab;
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] c;
        logic signed [63:0] w30;
        logic signed [63:0] w16;
        logic               neg;
        tab = '0;
        for (int i = 0; i < CURVE_ENTRIES; i++)
        begin
            t   = (PI_Q30 * 64'(i)) / 64'(CURVE_ENTRIES);
            neg = 1'b0;
            if (t > PI_Q30 / 64'd2)
            begin
                t   = PI_Q30 - t;
                neg = 1'b1;
            end
            t2   = (t * t) >> 30;
            term = ONE_Q30;
            sum  = $signed(ONE_Q30);
            for (int k = 1; k <= 8; k++)
            begin
                term = ((term * t2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if (k[0])
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            c   = neg ? -sum : sum;
            w30 = $signed(ONE_Q30) + c;
            if (w30 < 64'sd0)
            begin
                w30 = 64'sd0;
            end
            w16 = (w30 + 64'sd16384) >>> 15;
            if (w16 > 64'sd65536)
            begin
                w16 = 64'sd65536;
            end
            tab[i] = w16[16:0];
        end
        return tab;
    endfunction

    localparam curve_tab_t CURVE_TAB = build_curve();

    // multiply / constant modulo steps of the hash
    localparam logic [63:0] TWO32 = 64'h1_0000_0000;

    typedef struct packed {
        logic [19:0] k;
        logic [16:0] m;
        logic [17:0] r;
    } mm_const_t;

    typedef logic [3:0] pair_t;

    localparam int    MM_PAIRS = 11;
    localparam pair_t PAIR_X1  = 4'd0;
    localparam pair_t PAIR_X2  = 4'd1;
    localparam pair_t PAIR_Y1  = 4'd2;
    localparam pair_t PAIR_Y2  = 4'd3;
    localparam pair_t PAIR_Z1  = 4'd4;
    localparam pair_t PAIR_Z2  = 4'd5;
    localparam pair_t PAIR_L1  = 4'd6;
    localparam pair_t PAIR_L2  = 4'd7;
    localparam pair_t PAIR_R1  = 4'd8;
    localparam pair_t PAIR_R2  = 4'd9;
    localparam pair_t PAIR_FIN = 4'd10;

    localparam logic [16:0] FIN_M = 17'd65189;

    localparam mm_const_t MM_TAB [MM_PAIRS] = '{
        '{20'd143631, 17'd35417, 18'(TWO32 / 64'd35417)},
        '{20'd648861, 17'd89587, 18'(TWO32 / 64'd89587)},
        '{20'd984597, 17'd49873, 18'(TWO32 / 64'd49873)},
        '{20'd894389, 17'd48949, 18'(TWO32 / 64'd48949)},
        '{20'd121375, 17'd46187, 18'(TWO32 / 64'd46187)},
        '{20'd456883, 17'd46479, 18'(TWO32 / 64'd46479)},
        '{20'd464347, 17'd68445, 18'(TWO32 / 64'd68445)},
        '{20'd987645, 17'd16786, 18'(TWO32 / 64'd16786)},
        '{20'd164631, 17'd98415, 18'(TWO32 / 64'd98415)},
        '{20'd676431, 17'd78949, 18'(TWO32 / 64'd78949)},
        '{20'd0,      17'd65189, 18'(TWO32 / 64'd65189)}
    };

    localparam logic [19:0] MIX_K [4] = '{20'd846123, 20'd844619, 20'd687137, 20'd984685};

    // hash register file slots
    localparam logic [2:0] H_X0    = 3'd0;
    localparam logic [2:0] H_X1    = 3'd1;
    localparam logic [2:0] H_Y0    = 3'd2;
    localparam logic [2:0] H_Y1    = 3'd3;
    localparam logic [2:0] H_Z0    = 3'd4;
    localparam logic [2:0] H_Z1    = 3'd5;
    localparam logic [2:0] H_LAYER = 3'd6;
    localparam logic [2:0] H_MIX   = 3'd7;

    // configuration registers
    localparam int         APB_AW          = 4;
    localparam logic [1:0] REG_PERSISTENCE = 2'd0;
    localparam logic [1:0] REG_OCTAVES     = 2'd1;
    localparam logic [1:0] REG_BASE_AMP    = 2'd2;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       split;
        logic       mm_go;
        logic       mm_fin;
        logic [2:0] mm_src;
        pair_t      mm_pair;
        logic       mac_go;
        logic       mac_first;
        logic [2:0] mac_src;
        logic [1:0] mac_coef;
        logic [2:0] corner;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic mm_done;
        logic oct_done;
    } sts_t;

endpackage

/* rtl/fvn_ctrl.sv */
// ----------------------------------------------------------------------------
// fvn_ctrl
// Sequencer: walks octaves, hash chains, corner mixing and the output request
// handshake, issuing one datapath command at a time.
// ----------------------------------------------------------------------------
module fvn_ctrl #(
    parameter int MAX_OCTAVES = 16,
    parameter int LW          = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic [4:0]    octave_count,
    input  fvn_pkg::sts_t sts,
    output fvn_pkg::cmd_t cmd,
    output logic [LW-1:0] lvl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_HASH,
        S_HASH_WAIT,
        S_MAC,
        S_CHAIN,
        S_CHAIN_WAIT,
        S_OCT_WAIT,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [2:0]    hi_reg, hi_next;
    logic          pass_reg, pass_next;
    logic [2:0]    corner_reg, corner_next;
    logic [1:0]    mac_reg, mac_next;
    logic [1:0]    ch_reg, ch_next;
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] count;

    assign count = (octave_count > 5'(MAX_OCTAVES)) ? LW'(MAX_OCTAVES) : LW'(octave_count);

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        hi_next        = hi_reg;
        pass_next      = pass_reg;
        corner_next    = corner_reg;
        mac_next       = mac_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.corner     = corner_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    cmd.start = 1'b1;
                    lvl_next  = '0;
                    state_next = (count == '0) ? S_DONE : S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                hi_next    = fvn_pkg::H_X0;
                pass_next  = 1'b0;
                state_next = S_HASH;
            end
            S_HASH:
            begin
                cmd.mm_go   = 1'b1;
                cmd.mm_src  = hi_reg;
                cmd.mm_pair = fvn_pkg::pair_t'({hi_reg[2:1], 1'b0})
                            + fvn_pkg::pair_t'(pass_reg);
                state_next  = S_HASH_WAIT;
            end
            S_HASH_WAIT:
            begin
                if (sts.mm_done)
                begin
                    if (hi_reg == fvn_pkg::H_LAYER)
                    begin
                        hi_next = fvn_pkg::H_X0;
                        if (pass_reg)
                        begin
                            corner_next = '0;
                            mac_next    = '0;
                            state_next  = S_MAC;
                        end
                        else
                        begin
                            pass_next  = 1'b1;
                            state_next = S_HASH;
                        end
                    end
                    else
                    begin
                        hi_next    = hi_reg + 3'd1;
                        state_next = S_HASH;
                    end
                end
            end
            S_MAC:
            begin
                cmd.mac_go    = 1'b1;
                cmd.mac_first = (mac_reg == 2'd0);
                cmd.mac_coef  = mac_reg;
                case (mac_reg)
                    2'd0:    cmd.mac_src = fvn_pkg::H_X0 | {2'b00, corner_reg[2]};
                    2'd1:    cmd.mac_src = fvn_pkg::H_Y0 | {2'b00, corner_reg[1]};
                    2'd2:    cmd.mac_src = fvn_pkg::H_Z0 | {2'b00, corner_reg[0]};
                    default: cmd.mac_src = fvn_pkg::H_LAYER;
                endcase
                if (mac_reg == 2'd3)
                begin
                    ch_next    = '0;
                    state_next = S_CHAIN;
                end
                else
                begin
                    mac_next = mac_reg + 2'd1;
                end
            end
            S_CHAIN:
            begin
                cmd.mm_go   = 1'b1;
                cmd.mm_src  = fvn_pkg::H_MIX;
                cmd.mm_pair = fvn_pkg::PAIR_R1 + fvn_pkg::pair_t'(ch_reg);
                cmd.mm_fin  = (ch_reg == 2'd2);
                state_next  = S_CHAIN_WAIT;
            end
            S_CHAIN_WAIT:
            begin
                if (sts.mm_done)
                begin
                    if (ch_reg == 2'd2)
                    begin
                        if (corner_reg == 3'd7)
                        begin
                            state_next = S_OCT_WAIT;
                        end
                        else
                        begin
                            corner_next = corner_reg + 3'd1;
                            mac_next    = '0;
                            state_next  = S_MAC;
                        end
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_CHAIN;
                    end
                end
            end
            S_OCT_WAIT:
            begin
                if (sts.oct_done)
                begin
                    if (({1'b0, lvl_reg} + (LW+1)'(1)) == {1'b0, count})
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + LW'(1);
                        state_next = S_SPLIT;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            hi_reg        <= '0;
            pass_reg      <= 1'b0;
            corner_reg    <= '0;
            mac_reg       <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            hi_reg        <= hi_next;
            pass_reg      <= pass_next;
            corner_reg    <= corner_next;
            mac_reg       <= mac_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign lvl       = lvl_reg;

endmodule

/* rtl/fvn_dp.sv */
// ----------------------------------------------------------------------------
// fvn_dp
// Datapath: lattice split, hash register file, four-stage multiply and
// constant modulo unit, corner blend chain and octave accumulator.
// ----------------------------------------------------------------------------
module fvn_dp #(
    parameter int MAX_OCTAVES = 16,
    parameter int LW          = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  fvn_pkg::cmd_t cmd,
    input  logic [LW-1:0] lvl,
    input  logic [31:0]   pos_x,
    input  logic [31:0]   pos_y,
    input  logic [31:0]   pos_z,
    input  logic [15:0]   persistence,
    input  logic [15:0]   base_amplitude,
    output fvn_pkg::sts_t sts,
    output logic [15:0]   noise_value
);

    localparam int QW = 48 + MAX_OCTAVES;
    localparam int TW = 16 + $clog2(MAX_OCTAVES + 1);

    typedef struct packed {
        logic [31:0] lat;
        logic [16:0] w;
    } split_t;

    function automatic split_t split_axis(input logic [31:0] pos, input logic [LW-1:0] l);
        logic signed [QW-1:0] q;
        logic [15:0]          low;
        logic                 exact_neg;
        split_t               res;
        q         = $signed({{(QW-32){pos[31]}}, pos}) <<< l;
        low       = q[15:0];
        // negative whole number lands one lattice step lower with a fraction of one
        exact_neg = q[QW-1] && (low == 16'd0);
        res.lat   = q[47:16] - {31'd0, exact_neg};
        res.w     = exact_neg ? 17'd0
                  : fvn_pkg::CURVE_TAB[low[15:16-fvn_pkg::CURVE_IDX_W]];
        return res;
    endfunction

    // (a*w + b*(1-w)) >> 16 with a single product
    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [16:0] w);
        logic signed [17:0] diff;
        logic signed [35:0] prod;
        logic signed [36:0] sum;
        diff = $signed({2'b00, a}) - $signed({2'b00, b});
        prod = diff * $signed({1'b0, w});
        sum  = $signed({5'b00000, b, 16'h0000}) + $signed({prod[35], prod});
        return sum[31:16];
    endfunction

    logic [31:0]     px_reg, py_reg, pz_reg;
    logic [31:0]     hreg_reg [8];
    logic [16:0]     wx_reg, wy_reg, wz_reg;
    logic [15:0]     amp_reg;
    logic [TW-1:0]   total_reg;
    logic [15:0]     noise_reg;

    logic            s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic            s1_fin_reg, s2_fin_reg, s3_fin_reg;
    logic            s1_neg_reg, s2_neg_reg, s3_neg_reg;
    fvn_pkg::pair_t  s1_pair_reg, s2_pair_reg, s3_pair_reg;
    logic [2:0]      s1_src_reg, s2_src_reg, s3_src_reg;
    logic [2:0]      s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [31:0]     s1_a_reg, s2_a_reg;
    logic [49:0]     s2_m_reg;
    logic [17:0]     s3_q_reg, s3_r_reg;

    logic            cv_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic [2:0]      cv_tag_reg, d_tag_reg, e_tag_reg;
    logic [15:0]     cv_reg, zlo_reg, d_reg, ylo_reg, e_reg, xlo_reg, f_reg;

    split_t          sx, sy, sz;
    logic [31:0]     src_val;
    logic [51:0]     p_full;
    logic [31:0]     p;
    logic [31:0]     rabs;
    logic [17:0]     vred;
    logic [31:0]     s1_a_next;
    logic [49:0]     m_next;
    logic [17:0]     q_est;
    logic [34:0]     qm;
    logic [31:0]     r_raw;
    logic [16:0]     m3;
    logic [17:0]     r_fix, q_fix;
    logic [31:0]     mm_res;
    logic [51:0]     mac_prod;
    logic [31:0]     mac_sum;
    logic [31:0]     amp_prod;
    logic [31:0]     acc_prod;

    assign sx = split_axis(px_reg, lvl);
    assign sy = split_axis(py_reg, lvl);
    assign sz = split_axis(pz_reg, lvl);

    // issue stage: wrapping product and its magnitude
    assign src_val = hreg_reg[cmd.mm_src];
    assign p_full  = 52'(src_val) * 52'(fvn_pkg::MM_TAB[cmd.mm_pair].k);
    assign p       = p_full[31:0];
    assign rabs    = src_val[31] ? (32'd0 - src_val) : src_val;
    assign vred    = (rabs[17:0] >= 18'(fvn_pkg::FIN_M)) ? (rabs[17:0] - 18'(fvn_pkg::FIN_M))
                                                        : rabs[17:0];
    assign s1_a_next = cmd.mm_fin ? {vred[15:0], 16'h0000}
                                  : (p[31] ? (32'd0 - p) : p);

    // reciprocal estimate, low by at most one
    assign m_next = 50'(s1_a_reg) * 50'(fvn_pkg::MM_TAB[s1_pair_reg].r);
    assign q_est  = s2_m_reg[49:32];
    assign qm     = 35'(q_est) * 35'(fvn_pkg::MM_TAB[s2_pair_reg].m);
    assign r_raw  = s2_a_reg - qm[31:0];

    assign m3     = fvn_pkg::MM_TAB[s3_pair_reg].m;
    assign r_fix  = (s3_r_reg >= 18'(m3)) ? (s3_r_reg - 18'(m3)) : s3_r_reg;
    assign q_fix  = (s3_r_reg >= 18'(m3)) ? (s3_q_reg + 18'd1) : s3_q_reg;
    assign mm_res = s3_neg_reg ? (32'd0 - {14'd0, r_fix}) : {14'd0, r_fix};

    assign mac_prod = 52'(hreg_reg[cmd.mac_src]) * 52'(fvn_pkg::MIX_K[cmd.mac_coef]);
    assign mac_sum  = (cmd.mac_first ? 32'd0 : hreg_reg[fvn_pkg::H_MIX]) + mac_prod[31:0];

    assign amp_prod = 32'(amp_reg) * 32'(persistence);
    assign acc_prod = 32'(f_reg) * 32'(amp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            cv_vld_reg <= 1'b0;
            d_vld_reg  <= 1'b0;
            e_vld_reg  <= 1'b0;
            f_vld_reg  <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.mm_go;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            cv_vld_reg <= s3_vld_reg && s3_fin_reg;
            d_vld_reg  <= cv_vld_reg && cv_tag_reg[0];
            e_vld_reg  <= d_vld_reg && d_tag_reg[1];
            f_vld_reg  <= e_vld_reg && e_tag_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end

        if (cmd.split)
        begin
            hreg_reg[fvn_pkg::H_X0]    <= sx.lat;
            hreg_reg[fvn_pkg::H_X1]    <= sx.lat + 32'd1;
            hreg_reg[fvn_pkg::H_Y0]    <= sy.lat;
            hreg_reg[fvn_pkg::H_Y1]    <= sy.lat + 32'd1;
            hreg_reg[fvn_pkg::H_Z0]    <= sz.lat;
            hreg_reg[fvn_pkg::H_Z1]    <= sz.lat + 32'd1;
            hreg_reg[fvn_pkg::H_LAYER] <= 32'(lvl);
            wx_reg <= sx.w;
            wy_reg <= sy.w;
            wz_reg <= sz.w;
        end
        else if (s3_vld_reg && !s3_fin_reg)
        begin
            hreg_reg[s3_src_reg] <= mm_res;
        end
        else if (cmd.mac_go)
        begin
            hreg_reg[fvn_pkg::H_MIX] <= mac_sum;
        end

        if (cmd.start)
        begin
            amp_reg <= base_amplitude;
        end
        else if (cmd.split && (lvl != '0))
        begin
            amp_reg <= amp_prod[31:16];
        end

        if (cmd.start)
        begin
            total_reg <= '0;
        end
        else if (f_vld_reg)
        begin
            total_reg <= total_reg + TW'(acc_prod[31:16]);
        end

        if (cmd.out_load)
        begin
            noise_reg <= (|total_reg[TW-1:16]) ? 16'hFFFF : total_reg[15:0];
        end

        s1_fin_reg  <= cmd.mm_fin;
        s1_neg_reg  <= !cmd.mm_fin && p[31];
        s1_pair_reg <= cmd.mm_pair;
        s1_src_reg  <= cmd.mm_src;
        s1_tag_reg  <= cmd.corner;
        s1_a_reg    <= s1_a_next;

        s2_fin_reg  <= s1_fin_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_pair_reg <= s1_pair_reg;
        s2_src_reg  <= s1_src_reg;
        s2_tag_reg  <= s1_tag_reg;
        s2_a_reg    <= s1_a_reg;
        s2_m_reg    <= m_next;

        s3_fin_reg  <= s2_fin_reg;
        s3_neg_reg  <= s2_neg_reg;
        s3_pair_reg <= s2_pair_reg;
        s3_src_reg  <= s2_src_reg;
        s3_tag_reg  <= s2_tag_reg;
        s3_q_reg    <= q_est;
        s3_r_reg    <= r_raw[17:0];

        // blend along z, then y, then x as corners arrive
        cv_reg     <= q_fix[15:0];
        cv_tag_reg <= s3_tag_reg;
        if (cv_vld_reg && !cv_tag_reg[0])
        begin
            zlo_reg <= cv_reg;
        end
        d_reg     <= blend(zlo_reg, cv_reg, wz_reg);
        d_tag_reg <= cv_tag_reg;
        if (d_vld_reg && !d_tag_reg[1])
        begin
            ylo_reg <= d_reg;
        end
        e_reg     <= blend(ylo_reg, d_reg, wy_reg);
        e_tag_reg <= d_tag_reg;
        if (e_vld_reg && !e_tag_reg[2])
        begin
            xlo_reg <= e_reg;
        end
        f_reg <= blend(xlo_reg, e_reg, wx_reg);
    end

    assign sts.mm_done  = s3_vld_reg;
    assign sts.oct_done = f_vld_reg;
    assign noise_value  = noise_reg;

endmodule

/* rtl/fractal_value_noise_3d_top.sv */
// ----------------------------------------------------------------------------
// fractal_value_noise_3d_top
// One request at a time: no new request is taken until the last one's result is
// loaded. Each octave runs on the shared multiply/modulo unit, doing 14 hash steps
// plus 3 per corner, with 4 mixing steps per corner.
// Reset clears the sequencer and loads persistence 32768, octaves 8, base 32832.
// ----------------------------------------------------------------------------
module fractal_value_noise_3d_top #(
    parameter int MAX_OCTAVES = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fvn_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                pos_x,
    input  logic [31:0]                pos_y,
    input  logic [31:0]                pos_z,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [15:0]                noise_value
);

    localparam int LW = $clog2(MAX_OCTAVES + 1);

    logic [15:0]   persistence_reg;
    logic [4:0]    octave_count_reg;
    logic [15:0]   base_amplitude_reg;
    logic          wr_en;
    fvn_pkg::cmd_t cmd;
    fvn_pkg::sts_t sts;
    logic [LW-1:0] lvl;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persistence_reg    <= 16'd32768;
            octave_count_reg   <= 5'd8;
            base_amplitude_reg <= 16'd32832;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                fvn_pkg::REG_PERSISTENCE: persistence_reg    <= pwdata[15:0];
                fvn_pkg::REG_OCTAVES:     octave_count_reg   <= pwdata[4:0];
                fvn_pkg::REG_BASE_AMP:    base_amplitude_reg <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fvn_pkg::REG_PERSISTENCE: prdata = {16'd0, persistence_reg};
            fvn_pkg::REG_OCTAVES:     prdata = {27'd0, octave_count_reg};
            fvn_pkg::REG_BASE_AMP:    prdata = {16'd0, base_amplitude_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    fvn_ctrl #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .LW          (LW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .octave_count (octave_count_reg),
        .sts          (sts),
        .cmd          (cmd),
        .lvl          (lvl)
    );

    fvn_dp #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .LW          (LW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .lvl            (lvl),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .persistence    (persistence_reg),
        .base_amplitude (base_amplitude_reg),
        .sts            (sts),
        .noise_value    (noise_value)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after taking a request");

    a_mm_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mm_done |-> in_stall)
        else $error("modulo unit finished while idle");

    a_octave_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.oct_done |-> in_stall)
        else $error("octave finished while idle");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without work in progress");

endmodule
